@@ design/scc_pkg.sv @@
// Shared types and constants for the strong connectivity check core.
// Used by scc_ctrl, scc_dpath and strong_connectivity_check_core.
`default_nettype none

package scc_pkg;

  localparam int MaxVertices = 64;
  localparam int VidxW       = $clog2(MaxVertices);
  localparam int CountW      = $clog2(MaxVertices + 1);
  localparam int FieldW      = 7;

  typedef logic [VidxW-1:0]       vidx_t;
  typedef logic [CountW-1:0]      count_t;
  typedef logic [MaxVertices-1:0] vset_t;
  typedef logic [FieldW-1:0]      field_t;

  typedef enum logic [2:0] {
    StIdle,
    StRev,
    StSrcInit,
    StScan,
    StDrain,
    StEval
  } state_t;

  typedef struct packed {
    logic accept;
    logic wr_fwd;
    logic wr_rev;
    logic src_init;
    logic scan;
    logic rescan;
    logic next_src;
    logic finish;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic rev_needed;
    logic last_in;
    logic last_r;
    logic scan_last;
    logic src_last;
    logic full;
    logic grew;
  } status_t;

endpackage

`default_nettype wire

@@ design/scc_ctrl.sv @@
// Controller FSM: edge loading and the reach-set sweep for each source.
// Depends on scc_pkg; drives scc_dpath through cmd_t, reads status_t.
`default_nettype none

module scc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire scc_pkg::status_t status,
  output scc_pkg::cmd_t         cmd
);

  scc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      scc_pkg::StIdle: begin
        if (start) begin
          cmd.accept = 1'b1;
          cmd.wr_fwd = status.edge_ok;
          if (status.rev_needed) begin
            state_nxt = scc_pkg::StRev;
          end else if (status.last_in) begin
            state_nxt = scc_pkg::StSrcInit;
          end
        end
      end
      scc_pkg::StRev: begin
        cmd.wr_rev = 1'b1;
        state_nxt  = status.last_r ? scc_pkg::StSrcInit : scc_pkg::StIdle;
      end
      scc_pkg::StSrcInit: begin
        cmd.src_init = 1'b1;
        state_nxt    = scc_pkg::StScan;
      end
      scc_pkg::StScan: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = scc_pkg::StDrain;
        end
      end
      // last row read lands and merges here
      scc_pkg::StDrain: begin
        state_nxt = scc_pkg::StEval;
      end
      scc_pkg::StEval: begin
        priority if (status.full) begin
          if (status.src_last) begin
            cmd.finish = 1'b1;
            cmd.result = 1'b1;
            state_nxt  = scc_pkg::StIdle;
          end else begin
            cmd.next_src = 1'b1;
            state_nxt    = scc_pkg::StSrcInit;
          end
        end else if (status.grew) begin
          cmd.rescan = 1'b1;
          state_nxt  = scc_pkg::StScan;
        end else begin
          // closure reached without covering all vertices
          cmd.finish = 1'b1;
          cmd.result = 1'b0;
          state_nxt  = scc_pkg::StIdle;
        end
      end
      default: begin
        state_nxt = scc_pkg::StIdle;
      end
    endcase
  end

  assign busy = (state_r != scc_pkg::StIdle);

endmodule

`default_nettype wire

@@ design/scc_dpath.sv @@
// Datapath: vertex count register, adjacency row memory with row valid flags,
// reach-set sweep registers and result register. Depends on scc_pkg.
`default_nettype none

module scc_dpath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire scc_pkg::cmd_t         cmd,
  output scc_pkg::status_t           status,
  input  wire scc_pkg::field_t       in_from_vertex,
  input  wire scc_pkg::field_t       in_to_vertex,
  input  wire logic                  in_two_way,
  input  wire logic                  in_last_edge,
  input  wire logic                  cfg_valid,
  input  wire scc_pkg::field_t       cfg_data,
  output logic                       out_valid,
  output logic                       out_connected
);

  // configuration
  scc_pkg::field_t vcount_r;
  scc_pkg::count_t n_act;
  scc_pkg::vset_t  mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= scc_pkg::FieldW'(1);
    end else if (cfg_valid) begin
      vcount_r <= cfg_data;
    end
  end

  always_comb begin
    if (vcount_r == '0) begin
      n_act = scc_pkg::CountW'(1);
    end else if (int'(vcount_r) > scc_pkg::MaxVertices) begin
      n_act = scc_pkg::CountW'(scc_pkg::MaxVertices);
    end else begin
      n_act = scc_pkg::CountW'(vcount_r);
    end
  end

  always_comb begin
    for (int i = 0; i < scc_pkg::MaxVertices; i++) begin
      mask[i] = (i < int'(n_act));
    end
  end

  // edge capture
  scc_pkg::vidx_t from_idx, to_idx;
  scc_pkg::vidx_t from_idx_r, to_idx_r;
  logic           last_r;
  logic           edge_ok;

  assign from_idx = scc_pkg::VidxW'(in_from_vertex - scc_pkg::FieldW'(1));
  assign to_idx   = scc_pkg::VidxW'(in_to_vertex - scc_pkg::FieldW'(1));
  assign edge_ok  = (in_from_vertex != '0) && (int'(in_from_vertex) <= int'(n_act)) &&
                    (in_to_vertex != '0) && (int'(in_to_vertex) <= int'(n_act));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (cmd.accept) begin
      last_r <= in_last_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      from_idx_r <= from_idx;
      to_idx_r   <= to_idx;
    end
  end

  // adjacency memory; a row not written since the last check reads as zero
  scc_pkg::vset_t adj_mem [scc_pkg::MaxVertices];
  scc_pkg::vset_t row_valid_r;
  scc_pkg::vset_t wr_onehot, wr_mask;
  scc_pkg::vidx_t wr_addr, wr_col;
  logic           wr_en;
  scc_pkg::vidx_t scan_r;
  scc_pkg::vset_t rd_row_r;
  logic           rd_rv_r;

  assign wr_en     = cmd.wr_fwd | cmd.wr_rev;
  assign wr_addr   = cmd.wr_fwd ? from_idx : to_idx_r;
  assign wr_col    = cmd.wr_fwd ? to_idx : from_idx_r;
  assign wr_onehot = scc_pkg::vset_t'(1) << wr_col;
  // first write to a stale row overwrites the whole row
  assign wr_mask   = row_valid_r[wr_addr] ? wr_onehot : '1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < scc_pkg::MaxVertices; i++) begin
        if (wr_mask[i]) begin
          adj_mem[wr_addr][i] <= wr_onehot[i];
        end
      end
    end
    rd_row_r <= adj_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_rv_r     <= 1'b0;
    end else begin
      rd_rv_r <= row_valid_r[scan_r];
      if (cmd.finish) begin
        row_valid_r <= '0;
      end else if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // reach-set sweep
  scc_pkg::vset_t visited_r, merged;
  scc_pkg::vidx_t src_r, rd_idx_r;
  logic           rd_pend_r, grew_r, do_merge;

  assign do_merge = rd_pend_r && rd_rv_r && visited_r[rd_idx_r];
  assign merged   = visited_r | (rd_row_r & mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r     <= '0;
      scan_r    <= '0;
      rd_pend_r <= 1'b0;
      grew_r    <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan;
      if (cmd.finish) begin
        src_r <= '0;
      end else if (cmd.next_src) begin
        src_r <= src_r + scc_pkg::VidxW'(1);
      end
      priority if (cmd.src_init || cmd.rescan) begin
        scan_r <= '0;
        grew_r <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_r <= scan_r + scc_pkg::VidxW'(1);
        end
        if (do_merge && (merged != visited_r)) begin
          grew_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r;
    if (cmd.src_init) begin
      visited_r <= scc_pkg::vset_t'(1) << src_r;
    end else if (do_merge) begin
      visited_r <= merged;
    end
  end

  // result beat
  logic out_valid_r, out_connected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_connected_r <= cmd.result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_connected = out_connected_r;

  always_comb begin
    status            = '0;
    status.edge_ok    = edge_ok;
    status.rev_needed = edge_ok & in_two_way;
    status.last_in    = in_last_edge;
    status.last_r     = last_r;
    status.scan_last  = (scc_pkg::CountW'(scan_r) == (n_act - scc_pkg::CountW'(1)));
    status.src_last   = (scc_pkg::CountW'(src_r) == (n_act - scc_pkg::CountW'(1)));
    status.full       = ((visited_r & mask) == mask);
    status.grew       = grew_r;
  end

endmodule

`default_nettype wire

@@ design/strong_connectivity_check_core.sv @@
// Top level of the strong connectivity check core.
// Instantiates scc_ctrl and scc_dpath; depends on scc_pkg.
//
//   channel  handshake            payload
//   input    start / busy         in_from_vertex, in_to_vertex, in_two_way, in_last_edge
//   result   out_valid (strobe)   out_connected
//   config   cfg_valid/cfg_ready  cfg_data (vertex_count)
//
// A one-way or ignored edge is taken in StIdle; a two-way edge also writes a second row in StRev.
// On a last edge the sweep runs per source: a source init, then passes of n row reads
// through the single memory port, a drain and an evaluate step; up to n - 1 passes
// per source, one when n is 1. It stops at the first source that misses a vertex.
// Reset (rst_n low, synchronous) empties the graph and sets vertex_count to 1.
// The result beat follows the last evaluate cycle; the receiver cannot stall it.
`default_nettype none

module strong_connectivity_check_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire scc_pkg::field_t in_from_vertex,
  input  wire scc_pkg::field_t in_to_vertex,
  input  wire logic            in_two_way,
  input  wire logic            in_last_edge,
  output logic                 out_valid,
  output logic                 out_connected,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire scc_pkg::field_t cfg_data
);

  scc_pkg::cmd_t    cmd;
  scc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  scc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  scc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_from_vertex (in_from_vertex),
    .in_to_vertex   (in_to_vertex),
    .in_two_way     (in_two_way),
    .in_last_edge   (in_last_edge),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_connected  (out_connected)
  );

endmodule

`default_nettype wire
